@@ src/atd_pkg.sv @@
// Shared types and codes for the actor task dispatcher.
`timescale 1ns / 1ps
package atd_pkg;

  localparam int ID_W   = 6;
  localparam int WID_W  = 3;
  localparam int CNT_W  = 4;
  localparam int CFG_W  = 6;
  localparam logic [3:0] MAX_DISPATCH = 4'd8;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_READY  = 3'd1,
    OP_PUSH   = 3'd2,
    OP_RETURN = 3'd3,
    OP_ERASE  = 3'd4,
    OP_SUSP   = 3'd5,
    OP_RESUME = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    AS_ABSENT  = 3'd0,
    AS_INIT    = 3'd1,
    AS_FREE    = 3'd2,
    AS_LISTED  = 3'd3,
    AS_RUNNING = 3'd4
  } act_state_t;

  typedef enum logic [2:0] {
    STS_OK   = 3'd0,
    STS_DUP  = 3'd1,
    STS_UNAV = 3'd2,
    STS_MISS = 3'd3,
    STS_DONE = 3'd4
  } status_t;

  localparam logic KIND_STATUS   = 1'b0;
  localparam logic KIND_DISPATCH = 1'b1;

  localparam logic CFG_WORKER_COUNT = 1'b0;
  localparam logic CFG_ROUTE_ACTOR  = 1'b1;

  typedef enum logic [3:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_RD1,
    FSM_RD2,
    FSM_REMOVE,
    FSM_STATUS,
    FSM_D_RD,
    FSM_D_ACT,
    FSM_D_WR
  } fsm_t;

endpackage

@@ src/atd_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module atd_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read; the read data holds when no read is issued.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/actor_task_dispatcher.sv @@
// Top level of the actor task dispatcher: sequencer, worker pools and state memories.
//
//   Channel | Direction | Handshake           | Word
//   in_     | input     | in_valid / in_stall | operation with actor, worker and flags
//   out_    | output    | out_valid/out_stall | status or dispatch result
//   cfg_    | input     | cfg_wr_en           | register index and data
//
// An operation reads its actor word, and for a forwarded push the route actor, before its
// status word; when a listed actor is erased, a queue scan comes in between. Each dispatch
// that follows does a queue read, an actor read and an actor write-back. After reset a
// clearing pass zeroes the actor memory before the first word is accepted. A stalled
// output holds the sequencer in place; a new word is taken while the last result still
// waits in the output register.
`timescale 1ns / 1ps
module actor_task_dispatcher #(
  parameter int ACTOR_SLOTS = 64,
  parameter int WORKERS     = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [2:0]              in_operation,
  input  logic [atd_pkg::ID_W-1:0]  in_actor_id,
  input  logic [atd_pkg::WID_W-1:0] in_worker_id,
  input  logic                    in_start_free,
  input  logic                    in_forward,
  input  logic                    in_more_pending,
  input  logic                    in_has_callback,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_kind,
  output logic [2:0]              out_status,
  output logic [atd_pkg::ID_W-1:0]  out_actor_out,
  output logic [atd_pkg::WID_W-1:0] out_worker_out,
  output logic [atd_pkg::CNT_W-1:0] out_suspended_count,
  output logic                    out_last,
  input  logic                    cfg_wr_en,
  input  logic                    cfg_index,
  input  logic [atd_pkg::CFG_W-1:0] cfg_wdata
);
  import atd_pkg::*;

  localparam int AW = $clog2(ACTOR_SLOTS);
  localparam int CW = $clog2(ACTOR_SLOTS + 1);
  localparam int PW = (WORKERS < 8) ? WORKERS : 8;

  // Effective worker count, clamped to one up to the pool size.
  function automatic logic [CNT_W-1:0] eff_of(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) r = CNT_W'(1);
    if (32'(v) > PW) r = CNT_W'(PW);
    return r;
  endfunction

  // Position in the circular ready queue.
  function automatic logic [AW-1:0] qpos(input logic [AW-1:0] b, input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, b} + {1'b0, off};
    if (32'(s) >= ACTOR_SLOTS) s = s - (AW+1)'(ACTOR_SLOTS);
    return s[AW-1:0];
  endfunction

  function automatic logic in_range(input logic [ID_W-1:0] id);
    return 32'(id) < ACTOR_SLOTS;
  endfunction

  fsm_t fsm_r, fsm_nxt;

  // Registers.
  logic [CNT_W-1:0] wc_r, wc_nxt;
  logic [ID_W-1:0]  route_r, route_nxt;
  logic             susp_r, susp_nxt;
  logic [WID_W-1:0] idle_r [PW];
  logic [WID_W-1:0] idle_nxt [PW];
  logic [WID_W-1:0] spool_r [PW];
  logic [WID_W-1:0] spool_nxt [PW];
  logic [CNT_W-1:0] ic_r, ic_nxt;
  logic [CNT_W-1:0] sc_r, sc_nxt;
  logic [AW-1:0]    head_r, head_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;
  logic [CW-1:0]    k_r, k_nxt;
  logic             pv_r, pv_nxt;
  logic [AW-1:0]    ppos_r, ppos_nxt;
  logic             found_r, found_nxt;
  logic [3:0]       n_r, n_nxt;
  logic [ID_W-1:0]  act_r, act_nxt;
  logic [2:0]       op_r, op_nxt;
  logic [ID_W-1:0]  a_r, a_nxt;
  logic [WID_W-1:0] w_r, w_nxt;
  logic             sf_r, sf_nxt;
  logic             fwd_r, fwd_nxt;
  logic             more_r, more_nxt;
  logic             cb_r, cb_nxt;
  logic [2:0]       st_r, st_nxt;
  logic [ID_W-1:0]  aout_r, aout_nxt;
  logic             ov_r, ov_nxt;
  logic             ok_r, ok_nxt;
  logic [2:0]       os_r, os_nxt;
  logic [ID_W-1:0]  oa_r, oa_nxt;
  logic [WID_W-1:0] ow_r, ow_nxt;
  logic [CNT_W-1:0] osc_r, osc_nxt;
  logic             ol_r, ol_nxt;

  // Memory ports.
  logic          act_we, act_re;
  logic [AW-1:0] act_waddr, act_raddr;
  logic [3:0]    act_wdata, act_rdata;
  logic          q_we, q_re;
  logic [AW-1:0] q_waddr, q_raddr;
  logic [ID_W-1:0] q_wdata, q_rdata;

  // Actor state with erase-pending flag in the top bit.
  atd_ram #(.WIDTH(4), .DEPTH(ACTOR_SLOTS)) u_act_mem (
    .clk(clk), .we(act_we), .waddr(act_waddr), .wdata(act_wdata),
    .re(act_re), .raddr(act_raddr), .rdata(act_rdata)
  );

  // Ready queue of actor ids.
  atd_ram #(.WIDTH(ID_W), .DEPTH(ACTOR_SLOTS)) u_ready_q (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .re(q_re), .raddr(q_raddr), .rdata(q_rdata)
  );

  // Shared decode of the current actor word.
  logic [ID_W-1:0] cur_id;
  logic            cur_inr;
  logic [3:0]      rd_word;
  logic [2:0]      cur_s;
  logic            go_rd2, go_remove, rm_done, disp_ok, disp_last, out_free;

  assign cur_id    = (fsm_r == FSM_RD2) ? route_r : a_r;
  assign cur_inr   = in_range(cur_id);
  assign rd_word   = cur_inr ? act_rdata : 4'd0;
  assign cur_s     = rd_word[2:0];
  assign go_rd2    = (op_r == OP_PUSH) && (cur_s == AS_ABSENT) && fwd_r;
  assign go_remove = (op_r == OP_ERASE) && (cur_s == AS_LISTED);
  assign rm_done   = (k_r == cnt_r) && !pv_r;
  assign disp_ok   = !susp_r && (cnt_r != '0) && (ic_r != '0);
  assign disp_last = (n_r == MAX_DISPATCH - 4'd1) || (cnt_r == CW'(1)) || (ic_r == CNT_W'(1));
  assign out_free  = !ov_r || !out_stall;

  // Returning worker checks against the configured count and both pools.
  logic w_bad;
  always_comb begin
    w_bad = ({1'b0, w_r} >= eff_of(wc_r));
    for (int i = 0; i < PW; i++) begin
      if ((CNT_W'(i) < ic_r) && (idle_r[i] == w_r)) w_bad = 1'b1;
      if ((CNT_W'(i) < sc_r) && (spool_r[i] == w_r)) w_bad = 1'b1;
    end
  end

  // Next state.
  always_comb begin
    fsm_nxt = fsm_r;
    case (fsm_r)
      FSM_CLEAR:  if (32'(clr_r) == ACTOR_SLOTS - 1) fsm_nxt = FSM_IDLE;
      FSM_IDLE:   if (in_valid) fsm_nxt = FSM_RD1;
      FSM_RD1: begin
        if (go_rd2) fsm_nxt = FSM_RD2;
        else if (go_remove) fsm_nxt = FSM_REMOVE;
        else fsm_nxt = FSM_STATUS;
      end
      FSM_RD2:    fsm_nxt = FSM_STATUS;
      FSM_REMOVE: if (rm_done) fsm_nxt = FSM_STATUS;
      FSM_STATUS: if (out_free) fsm_nxt = disp_ok ? FSM_D_RD : FSM_IDLE;
      FSM_D_RD:   fsm_nxt = FSM_D_ACT;
      FSM_D_ACT:  fsm_nxt = FSM_D_WR;
      FSM_D_WR:   if (out_free) fsm_nxt = disp_last ? FSM_IDLE : FSM_D_RD;
      default:    fsm_nxt = FSM_IDLE;
    endcase
  end

  // Datapath, memory ports and output register.
  always_comb begin
    wc_nxt = wc_r; route_nxt = route_r; susp_nxt = susp_r;
    idle_nxt = idle_r; spool_nxt = spool_r; ic_nxt = ic_r; sc_nxt = sc_r;
    head_nxt = head_r; cnt_nxt = cnt_r; clr_nxt = clr_r;
    k_nxt = k_r; pv_nxt = 1'b0; ppos_nxt = ppos_r; found_nxt = found_r;
    n_nxt = n_r; act_nxt = act_r;
    op_nxt = op_r; a_nxt = a_r; w_nxt = w_r; sf_nxt = sf_r; fwd_nxt = fwd_r;
    more_nxt = more_r; cb_nxt = cb_r; st_nxt = st_r; aout_nxt = aout_r;
    ov_nxt = ov_r && out_stall;
    ok_nxt = ok_r; os_nxt = os_r; oa_nxt = oa_r; ow_nxt = ow_r;
    osc_nxt = osc_r; ol_nxt = ol_r;
    act_we = 1'b0; act_waddr = AW'(cur_id); act_wdata = 4'd0;
    act_re = 1'b0; act_raddr = AW'(in_actor_id);
    q_we = 1'b0; q_waddr = qpos(head_r, AW'(cnt_r)); q_wdata = cur_id;
    q_re = 1'b0; q_raddr = head_r;

    case (fsm_r)
      FSM_CLEAR: begin
        act_we    = 1'b1;
        act_waddr = clr_r;
        clr_nxt   = clr_r + AW'(1);
      end
      FSM_IDLE: begin
        if (in_valid) begin
          act_re = 1'b1;
          op_nxt = in_operation; a_nxt = in_actor_id; w_nxt = in_worker_id;
          sf_nxt = in_start_free; fwd_nxt = in_forward;
          more_nxt = in_more_pending; cb_nxt = in_has_callback;
        end
      end
      FSM_RD1, FSM_RD2: begin
        st_nxt   = STS_OK;
        aout_nxt = a_r;
        k_nxt    = '0;
        found_nxt = 1'b0;
        case (op_r)
          OP_ADD: begin
            if (!cur_inr) st_nxt = STS_MISS;
            else if (cur_s != AS_ABSENT) st_nxt = STS_DUP;
            else begin
              act_we    = 1'b1;
              act_wdata = {rd_word[3], sf_r ? AS_FREE : AS_INIT};
            end
          end
          OP_READY: begin
            if (cur_s == AS_ABSENT) st_nxt = STS_MISS;
            else if (cur_s == AS_INIT) begin
              act_we    = 1'b1;
              act_wdata = {rd_word[3], AS_FREE};
            end else st_nxt = STS_DUP;
          end
          OP_PUSH: begin
            if (fsm_r == FSM_RD1 && go_rd2) begin
              act_re    = 1'b1;
              act_raddr = AW'(route_r);
            end else if (cur_s == AS_ABSENT) st_nxt = STS_MISS;
            else begin
              aout_nxt = cur_id;
              if (cur_s == AS_INIT) st_nxt = STS_UNAV;
              else if (cur_s == AS_FREE) begin
                act_we    = 1'b1;
                act_wdata = {rd_word[3], AS_LISTED};
                q_we      = 1'b1;
                cnt_nxt   = cnt_r + CW'(1);
              end
            end
          end
          OP_RETURN: begin
            if (w_bad) st_nxt = STS_UNAV;
            else begin
              // The worker rejoins the pool that matches the suspend flag.
              for (int i = 0; i < PW; i++) begin
                if (susp_r && CNT_W'(i) == sc_r) spool_nxt[i] = w_r;
                if (!susp_r && CNT_W'(i) == ic_r) idle_nxt[i] = w_r;
              end
              if (susp_r) sc_nxt = sc_r + CNT_W'(1);
              else ic_nxt = ic_r + CNT_W'(1);
              if (cur_s == AS_ABSENT) begin
                if (rd_word[3]) begin
                  act_we    = 1'b1;
                  act_wdata = {1'b0, AS_ABSENT};
                  st_nxt    = STS_DONE;
                end else st_nxt = STS_MISS;
              end else if (cur_s == AS_RUNNING) begin
                act_we = 1'b1;
                if (more_r) begin
                  act_wdata = {rd_word[3], AS_LISTED};
                  q_we      = 1'b1;
                  cnt_nxt   = cnt_r + CW'(1);
                end else act_wdata = {rd_word[3], AS_FREE};
              end else st_nxt = STS_UNAV;
            end
          end
          OP_ERASE: begin
            if (cur_s == AS_ABSENT) st_nxt = STS_MISS;
            else if (cur_s == AS_RUNNING) begin
              act_we    = 1'b1;
              act_wdata = {rd_word[3] | cb_r, AS_ABSENT};
            end else begin
              act_we    = 1'b1;
              act_wdata = {rd_word[3], AS_ABSENT};
              st_nxt    = cb_r ? STS_DONE : STS_OK;
            end
          end
          OP_SUSP: begin
            susp_nxt = 1'b1;
            aout_nxt = '0;
            for (int i = 0; i < PW; i++) begin
              for (int j = 0; j < PW; j++) begin
                if ((CNT_W'(j) < ic_r) && (sc_r + CNT_W'(j) == CNT_W'(i)))
                  spool_nxt[i] = idle_r[j];
              end
            end
            sc_nxt = sc_r + ic_r;
            ic_nxt = '0;
          end
          OP_RESUME: begin
            susp_nxt = 1'b0;
            aout_nxt = '0;
            for (int i = 0; i < PW; i++) begin
              for (int j = 0; j < PW; j++) begin
                if ((CNT_W'(j) < sc_r) && (ic_r + CNT_W'(j) == CNT_W'(i)))
                  idle_nxt[i] = spool_r[j];
              end
            end
            ic_nxt = ic_r + sc_r;
            sc_nxt = '0;
          end
          default: st_nxt = STS_UNAV;
        endcase
      end
      FSM_REMOVE: begin
        // Scan the queue from its head and close the gap behind the erased actor.
        if (k_r != cnt_r) begin
          q_re     = 1'b1;
          q_raddr  = qpos(head_r, AW'(k_r));
          pv_nxt   = 1'b1;
          ppos_nxt = AW'(k_r);
          k_nxt    = k_r + CW'(1);
        end
        if (pv_r) begin
          if (found_r) begin
            q_we    = 1'b1;
            q_waddr = qpos(head_r, ppos_r - AW'(1));
            q_wdata = q_rdata;
          end else if (q_rdata == a_r) found_nxt = 1'b1;
        end
        if (rm_done) cnt_nxt = cnt_r - CW'(1);
      end
      FSM_STATUS: begin
        if (out_free) begin
          ov_nxt = 1'b1; ok_nxt = KIND_STATUS; os_nxt = st_r; oa_nxt = aout_r;
          ow_nxt = '0; osc_nxt = sc_r; ol_nxt = !disp_ok;
          n_nxt = '0;
        end
      end
      FSM_D_RD: begin
        q_re    = 1'b1;
        q_raddr = head_r;
      end
      FSM_D_ACT: begin
        act_nxt   = q_rdata;
        act_re    = 1'b1;
        act_raddr = AW'(q_rdata);
      end
      FSM_D_WR: begin
        if (out_free) begin
          act_we    = 1'b1;
          act_waddr = AW'(act_r);
          act_wdata = {act_rdata[3], AS_RUNNING};
          head_nxt  = qpos(head_r, AW'(1));
          cnt_nxt   = cnt_r - CW'(1);
          for (int i = 0; i < PW - 1; i++) idle_nxt[i] = idle_r[i+1];
          ic_nxt = ic_r - CNT_W'(1);
          ov_nxt = 1'b1; ok_nxt = KIND_DISPATCH; os_nxt = STS_OK; oa_nxt = act_r;
          ow_nxt = idle_r[0]; osc_nxt = sc_r; ol_nxt = disp_last;
          n_nxt  = n_r + 4'd1;
        end
      end
      default: ;
    endcase

    // The user must make configuration writes only while idle; the block itself does not enforce it.
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_WORKER_COUNT: begin
          wc_nxt = cfg_wdata[CNT_W-1:0];
          for (int i = 0; i < PW; i++) idle_nxt[i] = WID_W'(i);
          ic_nxt = eff_of(cfg_wdata[CNT_W-1:0]);
          sc_nxt = '0;
        end
        CFG_ROUTE_ACTOR: route_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r   <= FSM_CLEAR;
      clr_r   <= '0;
      wc_r    <= CNT_W'(8);
      route_r <= '0;
      susp_r  <= 1'b0;
      for (int i = 0; i < PW; i++) begin
        idle_r[i]  <= WID_W'(i);
        spool_r[i] <= '0;
      end
      ic_r    <= eff_of(CNT_W'(8));
      sc_r    <= '0;
      head_r  <= '0;
      cnt_r   <= '0;
      k_r     <= '0;
      pv_r    <= 1'b0;
      found_r <= 1'b0;
      n_r     <= '0;
      ov_r    <= 1'b0;
    end else begin
      fsm_r   <= fsm_nxt;
      clr_r   <= clr_nxt;
      wc_r    <= wc_nxt;
      route_r <= route_nxt;
      susp_r  <= susp_nxt;
      idle_r  <= idle_nxt;
      spool_r <= spool_nxt;
      ic_r    <= ic_nxt;
      sc_r    <= sc_nxt;
      head_r  <= head_nxt;
      cnt_r   <= cnt_nxt;
      k_r     <= k_nxt;
      pv_r    <= pv_nxt;
      found_r <= found_nxt;
      n_r     <= n_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    ppos_r <= ppos_nxt; act_r <= act_nxt;
    op_r <= op_nxt; a_r <= a_nxt; w_r <= w_nxt; sf_r <= sf_nxt; fwd_r <= fwd_nxt;
    more_r <= more_nxt; cb_r <= cb_nxt; st_r <= st_nxt; aout_r <= aout_nxt;
    ok_r <= ok_nxt; os_r <= os_nxt; oa_r <= oa_nxt; ow_r <= ow_nxt;
    osc_r <= osc_nxt; ol_r <= ol_nxt;
  end

  assign in_stall            = (fsm_r != FSM_IDLE);
  assign out_valid           = ov_r;
  assign out_kind            = ok_r;
  assign out_status          = os_r;
  assign out_actor_out       = oa_r;
  assign out_worker_out      = ow_r;
  assign out_suspended_count = osc_r;
  assign out_last            = ol_r;

endmodule

@@ tb/atd_checker.sv @@
// Checker for the actor task dispatcher: predicts every result word and compares it.
`timescale 1ns / 1ps
module atd_checker
  import atd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [2:0]       in_operation,
  input  logic [ID_W-1:0]  in_actor_id,
  input  logic [WID_W-1:0] in_worker_id,
  input  logic             in_start_free,
  input  logic             in_forward,
  input  logic             in_more_pending,
  input  logic             in_has_callback,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic             out_kind,
  input  logic [2:0]       out_status,
  input  logic [ID_W-1:0]  out_actor_out,
  input  logic [WID_W-1:0] out_worker_out,
  input  logic [CNT_W-1:0] out_suspended_count,
  input  logic             out_last,
  input  logic             cfg_wr_en,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  output int               fail_count,
  output int               words_pending
);

  typedef struct packed {
    logic             kind;
    logic [2:0]       status;
    logic [ID_W-1:0]  actor;
    logic [WID_W-1:0] worker;
    logic [CNT_W-1:0] scount;
    logic             last;
  } result_word_t;

  localparam int SLOTS = 64;
  localparam int NWORK = 8;
  localparam int MAX_WORDS = 9;

  // Shadow state of the dispatcher.
  act_state_t       slot_state [SLOTS];
  logic             erase_wait [SLOTS];
  logic [ID_W-1:0]  ready_fifo[$];
  logic [WID_W-1:0] idle_pool[$];
  logic [WID_W-1:0] held_pool[$];
  logic             halted;
  logic [3:0]       wcount_reg;
  logic [ID_W-1:0]  route_reg;
  result_word_t     expected_words[$];

  assign words_pending = expected_words.size();

  function automatic int live_workers();
    int w;
    w = wcount_reg;
    if (w < 1) w = 1;
    if (w > NWORK) w = NWORK;
    return w;
  endfunction

  function automatic void reseed_pools();
    int w;
    w = live_workers();
    idle_pool = {};
    held_pool = {};
    for (int i = 0; i < w; i++) idle_pool.insert(idle_pool.size(), i[WID_W-1:0]);
  endfunction

  function automatic bit worker_in_pool(logic [WID_W-1:0] w);
    foreach (idle_pool[i]) if (idle_pool[i] == w) return 1;
    foreach (held_pool[i]) if (held_pool[i] == w) return 1;
    return 0;
  endfunction

  function automatic void push_word(logic kind, status_t st, logic [ID_W-1:0] a,
                                    logic [WID_W-1:0] w);
    result_word_t r;
    r.kind   = kind;
    r.status = st;
    r.actor  = a;
    r.worker = w;
    r.scount = CNT_W'(held_pool.size());
    r.last   = 1'b0;
    expected_words.insert(expected_words.size(), r);
  endfunction

  // Apply one operation word to the shadow state and queue its results.
  function automatic void predict_word(logic [2:0] op, logic [ID_W-1:0] a,
                                       logic [WID_W-1:0] w, logic sfree, logic fwd,
                                       logic more, logic cb);
    status_t          st;
    logic [ID_W-1:0]  aout;
    logic [ID_W-1:0]  tgt;
    act_state_t       s;
    int               n;
    logic [ID_W-1:0]  act;
    logic [WID_W-1:0] wk;
    st   = STS_OK;
    aout = a;
    case (op)
      OP_ADD: begin
        if (slot_state[a] != AS_ABSENT) st = STS_DUP;
        else slot_state[a] = sfree ? AS_FREE : AS_INIT;
      end
      OP_READY: begin
        s = slot_state[a];
        if (s == AS_ABSENT) st = STS_MISS;
        else if (s == AS_INIT) slot_state[a] = AS_FREE;
        else st = STS_DUP;
      end
      OP_PUSH: begin
        tgt = a;
        if (slot_state[tgt] == AS_ABSENT && fwd) tgt = route_reg;
        s = slot_state[tgt];
        if (s == AS_ABSENT) begin
          st = STS_MISS;
        end else begin
          aout = tgt;
          if (s == AS_INIT) begin
            st = STS_UNAV;
          end else if (s == AS_FREE) begin
            slot_state[tgt] = AS_LISTED;
            ready_fifo.insert(ready_fifo.size(), tgt);
          end
        end
      end
      OP_RETURN: begin
        if (w >= live_workers() || worker_in_pool(w)) begin
          st = STS_UNAV;
        end else begin
          if (halted) held_pool.insert(held_pool.size(), w);
          else idle_pool.insert(idle_pool.size(), w);
          s = slot_state[a];
          if (s == AS_ABSENT) begin
            if (erase_wait[a]) begin
              erase_wait[a] = 1'b0;
              st = STS_DONE;
            end else begin
              st = STS_MISS;
            end
          end else if (s == AS_RUNNING) begin
            if (more) begin
              slot_state[a] = AS_LISTED;
              ready_fifo.insert(ready_fifo.size(), a);
            end else begin
              slot_state[a] = AS_FREE;
            end
          end else begin
            st = STS_UNAV;
          end
        end
      end
      OP_ERASE: begin
        s = slot_state[a];
        if (s == AS_ABSENT) begin
          st = STS_MISS;
        end else if (s == AS_RUNNING) begin
          slot_state[a] = AS_ABSENT;
          if (cb) erase_wait[a] = 1'b1;
        end else begin
          // A listed actor also leaves the ready queue.
          if (s == AS_LISTED) begin
            foreach (ready_fifo[i]) begin
              if (ready_fifo[i] == a) begin
                ready_fifo.delete(i);
                break;
              end
            end
          end
          slot_state[a] = AS_ABSENT;
          st = cb ? STS_DONE : STS_OK;
        end
      end
      OP_SUSP: begin
        halted = 1'b1;
        foreach (idle_pool[i])
          if (held_pool.size() < NWORK) held_pool.insert(held_pool.size(), idle_pool[i]);
        idle_pool = {};
        aout = '0;
      end
      OP_RESUME: begin
        halted = 1'b0;
        foreach (held_pool[i])
          if (idle_pool.size() < NWORK) idle_pool.insert(idle_pool.size(), held_pool[i]);
        held_pool = {};
        aout = '0;
      end
      default: st = STS_UNAV;
    endcase
    push_word(KIND_STATUS, st, aout, '0);
    n = 1;

    // Pair the oldest ready actors with the oldest idle workers.
    while (n < MAX_WORDS && !halted && ready_fifo.size() > 0 && idle_pool.size() > 0) begin
      act = ready_fifo[0];
      ready_fifo.delete(0);
      wk  = idle_pool[0];
      idle_pool.delete(0);
      slot_state[act] = AS_RUNNING;
      push_word(KIND_DISPATCH, STS_OK, act, wk);
      n++;
    end
    expected_words[expected_words.size()-1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    result_word_t got;
    result_word_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_state[i] = AS_ABSENT;
        erase_wait[i] = 1'b0;
      end
      ready_fifo     = {};
      halted         = 1'b0;
      wcount_reg     = 4'd8;
      route_reg      = '0;
      expected_words = {};
      fail_count     = 0;
      reseed_pools();
    end else begin
      // Register writes.
      if (cfg_wr_en) begin
        if (cfg_index == CFG_WORKER_COUNT) begin
          wcount_reg = cfg_wdata[3:0];
          reseed_pools();
        end else begin
          route_reg = cfg_wdata[ID_W-1:0];
        end
      end

      // Compare the accepted result word against the oldest expectation.
      if (out_valid && !out_stall) begin
        got = '{out_kind, out_status, out_actor_out, out_worker_out,
                out_suspended_count, out_last};
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word kind=%0d status=%0d actor=%0d worker=%0d susp=%0d last=%0d",
                   $realtime, got.kind, got.status, got.actor, got.worker, got.scount, got.last);
          fail_count++;
        end else begin
          want = expected_words[0];
          expected_words.delete(0);
          if (got !== want) begin
            $display("%0t: mismatch expected kind=%0d status=%0d actor=%0d worker=%0d susp=%0d last=%0d",
                     $realtime, want.kind, want.status, want.actor, want.worker, want.scount,
                     want.last);
            $display("%0t:          actual   kind=%0d status=%0d actor=%0d worker=%0d susp=%0d last=%0d",
                     $realtime, got.kind, got.status, got.actor, got.worker, got.scount,
                     got.last);
            fail_count++;
          end
        end
      end

      // Predict the results of an accepted operation word.
      if (in_valid && !in_stall)
        predict_word(in_operation, in_actor_id, in_worker_id, in_start_free, in_forward,
                     in_more_pending, in_has_callback);
    end
  end

endmodule

@@ tb/tb_actor_task_dispatcher.sv @@
// Testbench top for the actor task dispatcher: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module tb_actor_task_dispatcher;
  import atd_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 100;
  localparam int RANDOM_WORDS   = 200;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [2:0]       in_operation;
  logic [ID_W-1:0]  in_actor_id;
  logic [WID_W-1:0] in_worker_id;
  logic             in_start_free;
  logic             in_forward;
  logic             in_more_pending;
  logic             in_has_callback;
  logic             out_valid;
  logic             out_stall;
  logic             out_kind;
  logic [2:0]       out_status;
  logic [ID_W-1:0]  out_actor_out;
  logic [WID_W-1:0] out_worker_out;
  logic [CNT_W-1:0] out_suspended_count;
  logic             out_last;
  logic             cfg_wr_en;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_wdata;
  int               fail_count;
  int               words_pending;
  logic             no_gaps;
  int               quiet_cycles;

  // Actor and worker pairs seen in dispatch words, used for well-formed returns.
  logic [ID_W-1:0]  busy_actor[$];
  logic [WID_W-1:0] busy_worker[$];

  actor_task_dispatcher u_top (.*);

  atd_checker u_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_operation, .in_actor_id, .in_worker_id,
    .in_start_free, .in_forward, .in_more_pending, .in_has_callback,
    .out_valid, .out_stall, .out_kind, .out_status, .out_actor_out, .out_worker_out,
    .out_suspended_count, .out_last, .cfg_wr_en, .cfg_index, .cfg_wdata,
    .fail_count, .words_pending
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver stalls at random unless in a gap-free stretch.
  always @(negedge clk) begin
    if (!rst_n || no_gaps) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 26);
  end

  // Record dispatches and count cycles without any accepted word.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall && out_kind == KIND_DISPATCH) begin
      busy_actor.insert(busy_actor.size(), out_actor_out);
      busy_worker.insert(busy_worker.size(), out_worker_out);
    end
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL actor_task_dispatcher");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Send one operation word; returns at a falling edge with valid still high.
  task automatic send_op(op_t op, int a, int w, int sfree, int fwd, int more, int cb);
    while (!no_gaps && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_actor_id     <= ID_W'(a);
    in_worker_id    <= WID_W'(w);
    in_start_free   <= sfree[0];
    in_forward      <= fwd[0];
    in_more_pending <= more[0];
    in_has_callback <= cb[0];
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Return the worker of a random recorded dispatch, or a random worker if none.
  task automatic send_return(int more);
    int k;
    if (busy_actor.size() > 0) begin
      k = $urandom_range(busy_actor.size() - 1);
      send_op(OP_RETURN, busy_actor[k], busy_worker[k], $urandom_range(1), $urandom_range(1),
              more, $urandom_range(1));
      busy_actor.delete(k);
      busy_worker.delete(k);
    end else begin
      send_op(OP_RETURN, $urandom_range(63), $urandom_range(7), 0, 0, more, 0);
    end
  endtask

  // Drop valid and wait until every predicted word has come out.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (words_pending != 0) @(negedge clk);
  endtask

  // Write both registers once the block has gone idle.
  task automatic configure(logic [CFG_W-1:0] wcount, logic [CFG_W-1:0] route);
    in_valid <= 1'b0;
    wait_drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_WORKER_COUNT;
    cfg_wdata <= wcount;
    @(negedge clk);
    cfg_index <= CFG_ROUTE_ACTOR;
    cfg_wdata <= route;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    busy_actor  = {};
    busy_worker = {};
  endtask

  // Random operation mix over a small set of actors, with some noise.
  task automatic random_op();
    int pick;
    int a;
    pick = $urandom_range(99);
    a    = ($urandom_range(99) < 80) ? $urandom_range(7) : $urandom_range(63);
    if (pick < 15)
      send_op(OP_ADD, a, $urandom_range(7), $urandom_range(1), $urandom_range(1),
              $urandom_range(1), $urandom_range(1));
    else if (pick < 25)
      send_op(OP_READY, a, $urandom_range(7), $urandom_range(1), $urandom_range(1),
              $urandom_range(1), $urandom_range(1));
    else if (pick < 47)
      send_op(OP_PUSH, a, $urandom_range(7), $urandom_range(1), $urandom_range(1),
              $urandom_range(1), $urandom_range(1));
    else if (pick < 70)
      send_return($urandom_range(1));
    else if (pick < 76)
      send_op(OP_RETURN, a, $urandom_range(7), $urandom_range(1), $urandom_range(1),
              $urandom_range(1), $urandom_range(1));
    else if (pick < 86)
      send_op(OP_ERASE, a, $urandom_range(7), $urandom_range(1), $urandom_range(1),
              $urandom_range(1), $urandom_range(1));
    else if (pick < 91)
      send_op(OP_SUSP, a, $urandom_range(7), $urandom_range(1), $urandom_range(1),
              $urandom_range(1), $urandom_range(1));
    else if (pick < 97)
      send_op(OP_RESUME, a, $urandom_range(7), $urandom_range(1), $urandom_range(1),
              $urandom_range(1), $urandom_range(1));
    else
      send_op(op_t'(3'd7), a, $urandom_range(7), $urandom_range(1), $urandom_range(1),
              $urandom_range(1), $urandom_range(1));
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_operation    = OP_ADD;
    in_actor_id     = '0;
    in_worker_id    = '0;
    in_start_free   = 1'b0;
    in_forward      = 1'b0;
    in_more_pending = 1'b0;
    in_has_callback = 1'b0;
    out_stall       = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_index       = CFG_WORKER_COUNT;
    cfg_wdata       = '0;
    no_gaps         = 1'b0;
    quiet_cycles    = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: lifecycle of a few actors and each corner of the operations.
    configure(6'd8, 6'd63);
    send_op(OP_ADD, 0, 0, 0, 0, 0, 0);
    send_op(OP_ADD, 0, 0, 1, 0, 0, 0);
    send_op(OP_READY, 0, 0, 0, 0, 0, 0);
    send_op(OP_READY, 0, 0, 0, 0, 0, 0);
    send_op(OP_READY, 5, 0, 0, 0, 0, 0);
    send_op(OP_PUSH, 5, 0, 0, 0, 0, 0);
    send_op(OP_PUSH, 5, 0, 0, 1, 0, 0);
    send_op(OP_ADD, 63, 7, 1, 0, 0, 0);
    send_op(OP_PUSH, 9, 0, 0, 1, 0, 0);
    send_op(OP_ADD, 1, 0, 0, 0, 0, 0);
    send_op(OP_PUSH, 1, 0, 0, 0, 0, 0);
    send_op(OP_PUSH, 0, 0, 0, 0, 0, 0);
    send_op(OP_PUSH, 0, 0, 0, 0, 0, 0);
    send_op(OP_RETURN, 0, 7, 0, 0, 1, 0);
    wait_drain();
    send_return(1);
    send_op(OP_ERASE, 0, 0, 0, 0, 0, 1);
    wait_drain();
    send_return(0);
    send_op(OP_SUSP, 0, 0, 0, 0, 0, 0);
    send_op(OP_SUSP, 0, 0, 0, 0, 0, 0);
    send_op(OP_ADD, 3, 0, 1, 0, 0, 0);
    send_op(OP_PUSH, 3, 0, 0, 0, 0, 0);
    send_op(OP_ERASE, 3, 0, 0, 0, 0, 1);
    send_op(OP_RESUME, 0, 0, 0, 0, 0, 0);
    send_op(op_t'(3'd7), 63, 7, 1, 1, 1, 1);

    // Random part across several register settings, extremes included.
    configure(6'd0, 6'd0);
    for (int i = 0; i < 40; i++) random_op();
    configure(6'h3F, 6'd5);
    for (int i = 0; i < 50; i++) begin
      no_gaps = (i >= 15 && i < 40);
      random_op();
    end
    no_gaps = 1'b0;
    configure(6'd3, 6'd2);
    for (int i = 0; i < 50; i++) random_op();
    configure(6'd8, 6'd7);
    for (int i = 0; i < 60; i++) random_op();

    // Drain and give the verdict.
    in_valid <= 1'b0;
    wait_drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && words_pending == 0) begin
      $display("PASS actor_task_dispatcher");
    end else begin
      $display("FAIL actor_task_dispatcher");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/atd_pkg.sv
src/atd_ram.sv
src/actor_task_dispatcher.sv
tb/atd_checker.sv
tb/tb_actor_task_dispatcher.sv
